FILE: design/kwi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kwi_pkg;

	// Table geometry.
	localparam int TRACKS         = 16;
	localparam int KEYS_PER_TRACK = 256;

	// Field widths fixed by the interface.
	localparam int TRACK_W  = 4;
	localparam int SLOT_W   = 8;
	localparam int FRAME_W  = 32;
	localparam int WEIGHT_W = 16;
	localparam int STATUS_W = 2;

	// A key count reaches one more than the largest slot number.
	localparam int CNT_W     = SLOT_W + 1;
	localparam int ADDR_W    = $clog2(TRACKS * KEYS_PER_TRACK);
	localparam int TRK_IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	// The quotient never exceeds the weight difference, so one quotient bit
	// per weight bit suffices.
	localparam int DIV_STEPS = WEIGHT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int PROD_W    = FRAME_W + WEIGHT_W;
	localparam int SUM_W     = WEIGHT_W + 2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WRITE_ACK = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_COMPARE,
		S_SELECT,
		S_SINGLE,
		S_FETCH0,
		S_FETCH1,
		S_PREP,
		S_SATURATE,
		S_MULTIPLY,
		S_DIVIDE,
		S_FINISH,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_WRITE_ACK,
		RES_EMPTY,
		RES_KEY_WEIGHT,
		RES_W0,
		RES_INTERP
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     wr_en;
		logic     srch_init;
		logic     srch_read;
		logic     srch_step;
		logic     rd_found;
		logic     rd_next;
		logic     take_k0;
		logic     take_k1;
		logic     prep;
		logic     saturate;
		logic     multiply;
		logic     div_step;
		res_sel_t res_sel;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_write;
		logic empty;
		logic srch_open;
		logic found_edge;
		logic unordered;
		logic div_done;
		logic out_free;
	} ctl_status_t;

endpackage

`default_nettype wire

FILE: design/keyframe_weight_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyframe weight interpolator. The block keeps a sorted table of keys
// (frame, Q2.14 weight) for each of 16 tracks in two block RAMs of 4096
// entries, plus a 16-entry key count table that reset clears; the key RAMs
// need no clearing pass as long as the user sees that a key is read only
// after it was written, which the block itself does not enforce. A write
// item (kind 0) stores one key and answers with status 2; its last flag
// sets the track's key count. A query on an empty track returns status 1.
// A query item (kind 1) binary-searches the track for the last key at or
// below query_frame, one RAM read and one compare per halving step (up to
// nine steps for a full track), then fetches the bracketing keys and
// computes w0 + (w1 - w0) * (f - f0) / (f1 - f0) with the division
// truncated toward zero. The quotient comes from a restoring divider that
// yields one bit per cycle of its 16-bit result. The block works on one
// item at a time and holds in_stall high until the item's result sits in
// the output register, so the next transfer in comes in the cycle after
// the result is loaded at the earliest; the output register keeps the
// result through any out_stall while the next item is taken in.

module keyframe_weight_interpolator_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                kind,
	input  wire logic        [kwi_pkg::TRACK_W-1:0]  track,
	input  wire logic        [kwi_pkg::SLOT_W-1:0]   key_slot,
	input  wire logic        [kwi_pkg::FRAME_W-1:0]  key_frame,
	input  wire logic signed [kwi_pkg::WEIGHT_W-1:0] key_weight,
	input  wire logic                                key_last,
	input  wire logic        [kwi_pkg::FRAME_W-1:0]  query_frame,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [kwi_pkg::WEIGHT_W-1:0] weight_out,
	output logic             [kwi_pkg::STATUS_W-1:0] status
);

	import kwi_pkg::*;

	// The controller sequences the search and the divider; the datapath
	// holds the item, the key tables, the arithmetic and the output register.
	ctl_cmd_t    cmd;
	ctl_status_t sts;

	kwi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwi_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (kind),
		.track       (track),
		.key_slot    (key_slot),
		.key_frame   (key_frame),
		.key_weight  (key_weight),
		.key_last    (key_last),
		.query_frame (query_frame),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.weight_out  (weight_out),
		.status      (status)
	);

endmodule

`default_nettype wire

FILE: design/kwi_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kwi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/kwi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kwi_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire kwi_pkg::ctl_status_t sts,
	output kwi_pkg::ctl_cmd_t         cmd
);

	import kwi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_write || sts.empty) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH:   state_d = sts.srch_open ? S_COMPARE : S_SELECT;
			S_COMPARE:  state_d = S_SEARCH;
			S_SELECT:   state_d = sts.found_edge ? S_SINGLE : S_FETCH0;
			S_SINGLE:   state_d = S_DONE;
			S_FETCH0:   state_d = S_FETCH1;
			S_FETCH1:   state_d = S_PREP;
			S_PREP:     state_d = S_SATURATE;
			S_SATURATE: state_d = sts.unordered ? S_DONE : S_MULTIPLY;
			S_MULTIPLY: state_d = S_DIVIDE;
			S_DIVIDE: begin
				if (sts.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH:   state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_NONE;
		in_stall    = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_DECODE: begin
				if (sts.is_write) begin
					cmd.wr_en   = 1'b1;
					cmd.res_sel = RES_WRITE_ACK;
				end else if (sts.empty) begin
					cmd.res_sel = RES_EMPTY;
				end else begin
					cmd.srch_init = 1'b1;
				end
			end
			S_SEARCH:  cmd.srch_read = sts.srch_open;
			S_COMPARE: cmd.srch_step = 1'b1;
			S_SELECT:  cmd.rd_found  = 1'b1;
			S_SINGLE:  cmd.res_sel   = RES_KEY_WEIGHT;
			S_FETCH0: begin
				cmd.take_k0 = 1'b1;
				cmd.rd_next = 1'b1;
			end
			S_FETCH1:  cmd.take_k1 = 1'b1;
			S_PREP:    cmd.prep    = 1'b1;
			S_SATURATE: begin
				if (sts.unordered) begin
					cmd.res_sel = RES_W0;
				end else begin
					cmd.saturate = 1'b1;
				end
			end
			S_MULTIPLY: cmd.multiply = 1'b1;
			S_DIVIDE:   cmd.div_step = 1'b1;
			S_FINISH:   cmd.res_sel  = RES_INTERP;
			S_DONE:     cmd.out_load = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/kwi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kwi_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                kind,
	input  wire logic        [kwi_pkg::TRACK_W-1:0]  track,
	input  wire logic        [kwi_pkg::SLOT_W-1:0]   key_slot,
	input  wire logic        [kwi_pkg::FRAME_W-1:0]  key_frame,
	input  wire logic signed [kwi_pkg::WEIGHT_W-1:0] key_weight,
	input  wire logic                                key_last,
	input  wire logic        [kwi_pkg::FRAME_W-1:0]  query_frame,
	input  wire kwi_pkg::ctl_cmd_t                   cmd,
	output kwi_pkg::ctl_status_t                     sts,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [kwi_pkg::WEIGHT_W-1:0] weight_out,
	output logic             [kwi_pkg::STATUS_W-1:0] status
);

	import kwi_pkg::*;

	// Captured item.
	logic                       kind_q;
	logic [TRACK_W-1:0]         track_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [FRAME_W-1:0]         kframe_q;
	logic signed [WEIGHT_W-1:0] kweight_q;
	logic                       klast_q;
	logic [FRAME_W-1:0]         qframe_q;

	logic [CNT_W-1:0] counts_q [TRACKS];

	logic [CNT_W-1:0] lo_q, hi_q, n_q;
	logic [FRAME_W-1:0] f0_q, f1_q, den_q, num_q;
	logic signed [WEIGHT_W-1:0] w0_q, w1_q;
	logic unordered_q, neg_q;
	logic [WEIGHT_W-1:0]  mag_q;
	logic [PROD_W-1:0]    rem_q, dsr_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic signed [WEIGHT_W-1:0] res_w_q;
	logic [STATUS_W-1:0]        res_st_q;
	logic                       out_valid_q;
	logic signed [WEIGHT_W-1:0] weight_out_q;
	logic [STATUS_W-1:0]        status_q;

	logic                  track_ok, slot_ok;
	logic [TRK_IDX_W-1:0]  trk_idx;
	logic [CNT_W-1:0]      cnt_raw, cnt_n, mid, found_idx, rd_idx;
	logic [ADDR_W-1:0]     base, wr_addr, rd_addr;
	logic                  wr_do, rd_en;
	logic [FRAME_W-1:0]    rd_frame;
	logic signed [WEIGHT_W-1:0] rd_weight;
	logic [FRAME_W:0]      den_ext;
	logic signed [WEIGHT_W:0] diff;
	logic [WEIGHT_W:0]     diff_neg;
	logic [PROD_W-1:0]     prod;
	logic                  rem_ge;
	logic signed [SUM_W-1:0] q_signed, sum;

	assign track_ok = int'(track_q) < TRACKS;
	assign slot_ok  = int'(slot_q) < KEYS_PER_TRACK;
	assign trk_idx  = TRK_IDX_W'(track_q);
	assign cnt_raw  = counts_q[trk_idx];
	assign cnt_n    = (int'(cnt_raw) > KEYS_PER_TRACK) ? CNT_W'(KEYS_PER_TRACK) : cnt_raw;
	assign base     = ADDR_W'(ADDR_W'(track_q) * ADDR_W'(KEYS_PER_TRACK));
	assign wr_addr  = base + ADDR_W'(slot_q);
	assign wr_do    = cmd.wr_en && track_ok && slot_ok;

	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign found_idx = (lo_q == '0) ? '0 : lo_q - CNT_W'(1);

	always_comb begin
		if (cmd.srch_read) begin
			rd_idx = mid;
		end else if (cmd.rd_found) begin
			rd_idx = found_idx;
		end else begin
			rd_idx = lo_q;
		end
	end

	assign rd_addr = base + ADDR_W'(rd_idx);
	assign rd_en   = cmd.srch_read || cmd.rd_found || cmd.rd_next;

	kwi_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (TRACKS * KEYS_PER_TRACK)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (wr_do),
		.wr_addr (wr_addr),
		.wr_data (kframe_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_frame)
	);

	kwi_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (TRACKS * KEYS_PER_TRACK)
	) u_weight_ram (
		.clk     (clk),
		.wr_en   (wr_do),
		.wr_addr (wr_addr),
		.wr_data (kweight_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_weight)
	);

	assign den_ext  = {1'b0, f1_q} - {1'b0, f0_q};
	assign diff     = {w1_q[WEIGHT_W-1], w1_q} - {w0_q[WEIGHT_W-1], w0_q};
	assign diff_neg = -diff;
	assign prod     = {{FRAME_W{1'b0}}, mag_q} * {{WEIGHT_W{1'b0}}, num_q};
	assign rem_ge   = rem_q >= dsr_q;
	assign q_signed = neg_q ? -SUM_W'($signed({2'b00, quo_q})) : SUM_W'($signed({2'b00, quo_q}));
	assign sum      = SUM_W'(w0_q) + q_signed;

	// Item capture and the key count table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TRACKS; t++) begin
				counts_q[t] <= '0;
			end
		end else if (wr_do && klast_q) begin
			counts_q[trk_idx] <= CNT_W'(slot_q) + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= kind;
			track_q   <= track;
			slot_q    <= key_slot;
			kframe_q  <= key_frame;
			kweight_q <= key_weight;
			klast_q   <= key_last;
			qframe_q  <= query_frame;
		end
	end

	// Search bounds.
	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= cnt_n;
			n_q  <= cnt_n;
		end else if (cmd.srch_step) begin
			if (rd_frame <= qframe_q) begin
				lo_q <= mid + CNT_W'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

	// Interpolation arithmetic.
	always_ff @(posedge clk) begin
		if (cmd.take_k0) begin
			f0_q <= rd_frame;
			w0_q <= rd_weight;
		end
		if (cmd.take_k1) begin
			f1_q <= rd_frame;
			w1_q <= rd_weight;
		end
		if (cmd.prep) begin
			den_q       <= den_ext[FRAME_W-1:0];
			unordered_q <= den_ext[FRAME_W] || (den_ext[FRAME_W-1:0] == '0);
			num_q       <= qframe_q - f0_q;
			neg_q       <= diff[WEIGHT_W];
			mag_q       <= diff[WEIGHT_W] ? diff_neg[WEIGHT_W-1:0] : diff[WEIGHT_W-1:0];
		end
		if (cmd.saturate && (num_q > den_q)) begin
			num_q <= den_q;
		end
		if (cmd.multiply) begin
			rem_q     <= prod;
			dsr_q     <= PROD_W'(den_q) << (DIV_STEPS - 1);
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q     <= {quo_q[DIV_STEPS-2:0], rem_ge};
			dsr_q     <= dsr_q >> 1;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// Result staging.
	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			RES_WRITE_ACK: begin
				res_w_q  <= '0;
				res_st_q <= STATUS_WRITE_ACK;
			end
			RES_EMPTY: begin
				res_w_q  <= '0;
				res_st_q <= STATUS_EMPTY;
			end
			RES_KEY_WEIGHT: begin
				res_w_q  <= rd_weight;
				res_st_q <= STATUS_OK;
			end
			RES_W0: begin
				res_w_q  <= w0_q;
				res_st_q <= STATUS_OK;
			end
			RES_INTERP: begin
				res_w_q  <= sum[WEIGHT_W-1:0];
				res_st_q <= STATUS_OK;
			end
			default: begin
				res_w_q  <= res_w_q;
				res_st_q <= res_st_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			weight_out_q <= res_w_q;
			status_q     <= res_st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_out = weight_out_q;
	assign status     = status_q;

	always_comb begin
		sts            = '0;
		sts.is_write   = (kind_q == KIND_WRITE);
		sts.empty      = (kind_q == KIND_QUERY) && (!track_ok || (cnt_raw == '0));
		sts.srch_open  = lo_q < hi_q;
		sts.found_edge = (lo_q == '0) || (lo_q == n_q);
		sts.unordered  = unordered_q;
		sts.div_done   = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
		sts.out_free   = !out_valid_q || !out_stall;
	end

endmodule

`default_nettype wire

FILE: design/kwi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kwi_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic signed [kwi_pkg::WEIGHT_W-1:0] weight_out,
	input  wire logic        [kwi_pkg::STATUS_W-1:0] status
);

	import kwi_pkg::*;

	// A result waiting on the output side holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(weight_out) && $stable(status))
		else $error("stalled result changed");

	// Write acknowledgements and empty-track answers carry a zero weight.
	a_nonok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_OK) |-> weight_out == '0)
		else $error("non-query result with nonzero weight");

	// One item at a time: after an input transfer the block stalls.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

endmodule

bind keyframe_weight_interpolator_core kwi_checker u_kwi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.weight_out (weight_out),
	.status     (status)
);

`default_nettype wire

FILE: bench/weight_checker.sv
`timescale 1ns / 1ps

module weight_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                kind,
	input  logic        [kwi_pkg::TRACK_W-1:0]  track,
	input  logic        [kwi_pkg::SLOT_W-1:0]   key_slot,
	input  logic        [kwi_pkg::FRAME_W-1:0]  key_frame,
	input  logic signed [kwi_pkg::WEIGHT_W-1:0] key_weight,
	input  logic                                key_last,
	input  logic        [kwi_pkg::FRAME_W-1:0]  query_frame,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [kwi_pkg::WEIGHT_W-1:0] weight_out,
	input  logic        [kwi_pkg::STATUS_W-1:0] status,
	output int                                  mismatches,
	output int                                  pending
);
	import kwi_pkg::*;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic        [STATUS_W-1:0] code;
	} weight_result_t;

	logic        [FRAME_W-1:0]  frame_tab  [TRACKS*KEYS_PER_TRACK];
	logic signed [WEIGHT_W-1:0] weight_tab [TRACKS*KEYS_PER_TRACK];
	int unsigned                count_tab  [TRACKS];
	weight_result_t             expected_weights [$];

	initial mismatches = 0;
	initial pending = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Last key at or below the frame, then linear blend toward its successor.
	function automatic logic signed [WEIGHT_W-1:0] sample_keys(input int unsigned base,
		input int unsigned n, input logic [FRAME_W-1:0] f);
		int unsigned          lo, hi, mid, i;
		logic [FRAME_W-1:0]   f0, f1, span, past;
		longint               w0, w1, q;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (frame_tab[base + mid] <= f)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo == 0)
			return weight_tab[base];
		i = lo - 1;
		if (i == n - 1)
			return weight_tab[base + i];
		f0 = frame_tab[base + i];
		f1 = frame_tab[base + i + 1];
		if (f1 <= f0)
			return weight_tab[base + i];
		span = f1 - f0;
		past = f - f0;
		if (past > span)
			past = span;
		w0 = weight_tab[base + i];
		w1 = weight_tab[base + i + 1];
		q = ((w1 - w0) * longint'({32'd0, past})) / longint'({32'd0, span});
		return WEIGHT_W'(w0 + q);
	endfunction

	function automatic weight_result_t predict_weight(input logic k,
		input logic [TRACK_W-1:0] t, input logic [SLOT_W-1:0] s,
		input logic [FRAME_W-1:0] kf, input logic signed [WEIGHT_W-1:0] kw,
		input logic l, input logic [FRAME_W-1:0] qf);
		weight_result_t r;
		int unsigned    addr, n;
		r.weight = '0;
		if (k == KIND_WRITE) begin
			if (int'(t) < TRACKS && int'(s) < KEYS_PER_TRACK) begin
				addr = int'(t) * KEYS_PER_TRACK + int'(s);
				frame_tab[addr] = kf;
				weight_tab[addr] = kw;
				if (l)
					count_tab[t] = int'(s) + 1;
			end
			r.code = STATUS_WRITE_ACK;
		end else if (int'(t) >= TRACKS || count_tab[t] == 0) begin
			r.code = STATUS_EMPTY;
		end else begin
			n = (count_tab[t] > KEYS_PER_TRACK) ? KEYS_PER_TRACK : count_tab[t];
			r.weight = sample_keys(int'(t) * KEYS_PER_TRACK, n, qf);
			r.code = STATUS_OK;
		end
		return r;
	endfunction

	// Results are checked before the new item is predicted, so an item can never
	// be matched against its own result within the same edge.
	always @(posedge clk or negedge arst_n) begin
		weight_result_t want;
		if (!arst_n) begin
			expected_weights.delete();
			foreach (count_tab[t])
				count_tab[t] = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_weights.size() == 0) begin
					report("result with nothing pending", {14'd0, status, weight_out}, 32'd0);
				end else begin
					want = expected_weights.pop_front();
					if (weight_out !== want.weight)
						report("weight_out", {16'd0, weight_out}, {16'd0, want.weight});
					if (status !== want.code)
						report("status", {30'd0, status}, {30'd0, want.code});
				end
			end
			if (in_valid && !in_stall)
				expected_weights.push_back(predict_weight(kind, track, key_slot, key_frame,
					key_weight, key_last, query_frame));
			pending = expected_weights.size();
		end
	end

endmodule

FILE: bench/keyframe_weight_interpolator_core_tb.sv
`timescale 1ns / 1ps

module keyframe_weight_interpolator_core_tb;
	import kwi_pkg::*;

	// The slowest item is a full-track query; with the largest sender gap and
	// receiver stall on top, a run of about two thousand items stays far below
	// this bound.
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 60;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       kind;
	logic        [TRACK_W-1:0]  track;
	logic        [SLOT_W-1:0]   key_slot;
	logic        [FRAME_W-1:0]  key_frame;
	logic signed [WEIGHT_W-1:0] key_weight;
	logic                       key_last;
	logic        [FRAME_W-1:0]  query_frame;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [WEIGHT_W-1:0] weight_out;
	logic        [STATUS_W-1:0] status;

	int          mismatches;
	int          pending;
	int unsigned cycle_count;
	int unsigned items_sent;

	// When set, neither side inserts gaps or stalls, so transfers run back to back.
	bit quiet;

	// A mirror of what has been written, so that the stimulus only ever raises a
	// key count over slots that hold a key and can aim queries near stored frames.
	bit                 key_written  [TRACKS][KEYS_PER_TRACK];
	logic [FRAME_W-1:0] frame_mirror [TRACKS][KEYS_PER_TRACK];
	int unsigned        count_mirror [TRACKS];

	keyframe_weight_interpolator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.track       (track),
		.key_slot    (key_slot),
		.key_frame   (key_frame),
		.key_weight  (key_weight),
		.key_last    (key_last),
		.query_frame (query_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.weight_out  (weight_out),
		.status      (status)
	);

	weight_checker weight_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.track       (track),
		.key_slot    (key_slot),
		.key_frame   (key_frame),
		.key_weight  (key_weight),
		.key_last    (key_last),
		.query_frame (query_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.weight_out  (weight_out),
		.status      (status),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// A hung handshake ends the run here rather than hanging the simulator.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// One transfer on the input channel. Fields change only at the falling edge
	// and stay put until the block takes them. Valid is left high after the
	// transfer, so a following item with no gap goes out without a bubble.
	task automatic send_item(input logic k, input logic [TRACK_W-1:0] t,
		input logic [SLOT_W-1:0] s, input logic [FRAME_W-1:0] kf,
		input logic signed [WEIGHT_W-1:0] kw, input logic l, input logic [FRAME_W-1:0] qf);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = k;
		track = t;
		key_slot = s;
		key_frame = kf;
		key_weight = kw;
		key_last = l;
		query_frame = qf;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		items_sent++;
		if (k == KIND_WRITE) begin
			key_written[t][s] = 1'b1;
			frame_mirror[t][s] = kf;
			if (l)
				count_mirror[t] = int'(s) + 1;
		end
	endtask

	// Unused fields carry random junk: the block has to ignore them.
	task automatic put_key(input int unsigned t, input int unsigned s,
		input logic [FRAME_W-1:0] kf, input logic signed [WEIGHT_W-1:0] kw, input logic l);
		send_item(KIND_WRITE, TRACK_W'(t), SLOT_W'(s), kf, kw, l, $urandom());
	endtask

	task automatic ask_weight(input int unsigned t, input logic [FRAME_W-1:0] qf);
		send_item(KIND_QUERY, TRACK_W'(t), SLOT_W'($urandom()), $urandom(),
			WEIGHT_W'($urandom()), 1'($urandom()), qf);
	endtask

	// Drops the valid and holds off until every result has come back.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 11))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd16384;
			3: return -16'sd16384;
			default: return WEIGHT_W'($urandom());
		endcase
	endfunction

	// A count may only cover slots that all hold a key, since the block would
	// otherwise read table entries that were never written.
	function automatic bit prefix_written(input int unsigned t, input int unsigned s);
		for (int unsigned j = 0; j < s; j++)
			if (!key_written[t][j])
				return 1'b0;
		return 1'b1;
	endfunction

	// Query frames cluster around stored keys: exact hits, one off on either
	// side, points between neighbors, ahead of the first key, and the extremes.
	function automatic logic [FRAME_W-1:0] pick_query_frame(input int unsigned t);
		int unsigned        n, j;
		logic [FRAME_W-1:0] lo_f, hi_f;
		n = count_mirror[t];
		j = $urandom_range(0, n - 1);
		lo_f = frame_mirror[t][j];
		hi_f = (j + 1 < n) ? frame_mirror[t][j + 1] : lo_f + 32'd1000;
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return '0;
			2: return '1;
			3: return frame_mirror[t][0] - $urandom_range(1, 100);
			4: return lo_f;
			5: return lo_f - 32'd1;
			6: return lo_f + 32'd1;
			default: return (hi_f > lo_f) ? lo_f + $urandom_range(0, hi_f - lo_f) : lo_f;
		endcase
	endfunction

	// Writes a whole table for one track, slot by slot, raising the count with
	// the last key. Ordered tables use strictly rising frames with a spacing
	// scale drawn per table; the sum cannot pass the top of the frame range.
	task automatic build_track(input int unsigned t, input int unsigned n, input bit ordered);
		logic [FRAME_W-1:0] f;
		int unsigned        step_max;
		case ($urandom_range(0, 2))
			0: step_max = 4;
			1: step_max = 1000;
			default: step_max = 1 << 23;
		endcase
		f = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 32'h7fff_ffff);
		for (int unsigned s = 0; s < n; s++) begin
			if (!ordered)
				f = $urandom();
			else if (s != 0)
				f = f + $urandom_range(1, step_max);
			put_key(t, s, f, pick_weight(), s == n - 1);
		end
	endtask

	// Result side: a random stall before each result, released until the
	// transfer happens. The quiet stretches take results as soon as they show.
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 8);
			if (hold != 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		int unsigned start, next_block, next_pause, choice, t, s, n;
		bit          l;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		track = '0;
		key_slot = '0;
		key_frame = '0;
		key_weight = '0;
		key_last = 1'b0;
		query_frame = '0;
		quiet = 1'b0;
		items_sent = 0;
		foreach (count_mirror[i])
			count_mirror[i] = 0;
		foreach (key_written[i, j])
			key_written[i][j] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Empty tracks first, while every count is still zero.
		ask_weight(0, $urandom());
		ask_weight(TRACKS - 1, $urandom());

		// A single key: ahead of it, on it, and far past it all give its weight.
		put_key(3, 0, 32'd100, 16'sd16384, 1'b1);
		ask_weight(3, 32'd0);
		ask_weight(3, 32'd100);
		ask_weight(3, '1);

		// Two keys spanning the whole frame range with extreme weights, which
		// gives the widest product and the widest divisor.
		put_key(5, 0, 32'd0, 16'sh8000, 1'b0);
		put_key(5, 1, 32'hffff_ffff, 16'sh7fff, 1'b1);
		ask_weight(5, 32'd0);
		ask_weight(5, 32'h7fff_ffff);
		ask_weight(5, 32'hffff_fffe);
		ask_weight(5, 32'hffff_ffff);

		// Falling weights make the quotient negative, so truncation toward zero
		// differs from flooring here.
		put_key(6, 0, 32'd10, 16'sh7fff, 1'b0);
		put_key(6, 1, 32'd20, 16'sh8000, 1'b0);
		put_key(6, 2, 32'd30, 16'sd0, 1'b1);
		ask_weight(6, 32'd15);
		ask_weight(6, 32'd13);
		ask_weight(6, 32'd25);
		ask_weight(6, 32'd5);

		// Rewriting a middle key without the last flag keeps the count, and a
		// last flag on slot zero shrinks the table back to one key.
		put_key(6, 1, 32'd20, -16'sd5, 1'b0);
		ask_weight(6, 32'd17);
		put_key(6, 0, 32'd10, 16'sd1, 1'b1);
		ask_weight(6, 32'd25);

		// The top slot can be written while the track stays empty.
		put_key(1, KEYS_PER_TRACK - 1, $urandom(), WEIGHT_W'($urandom()), 1'b0);
		ask_weight(1, $urandom());

		wait_idle();

		// Random part. One full-size table up front, then mostly small tables
		// with many queries, broken tables and stray writes mixed in. The last
		// track is held back for the first half so empty queries keep coming.
		start = items_sent;
		next_block = items_sent;
		next_pause = items_sent + 300;
		build_track(9, KEYS_PER_TRACK, 1'b1);
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent >= next_block) begin
				quiet = ($urandom_range(0, 3) == 0);
				next_block = items_sent + 100;
			end
			if (items_sent >= next_pause) begin
				wait_idle();
				next_pause = items_sent + $urandom_range(200, 400);
			end
			choice = $urandom_range(0, 99);
			t = $urandom_range(0, (items_sent - start < RANDOM_ITEMS / 2) ? TRACKS - 2 : TRACKS - 1);
			if (choice < 7) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, KEYS_PER_TRACK)
				                                 : $urandom_range(1, 12);
				build_track(t, n, 1'b1);
			end else if (choice < 10) begin
				build_track(t, $urandom_range(1, 6), 1'b0);
			end else if (choice < 18) begin
				// Stray write: often over a live key, which may leave the table
				// out of order; the count moves only where it stays safe.
				s = (count_mirror[t] != 0 && $urandom_range(0, 1) == 1)
				    ? $urandom_range(0, count_mirror[t] - 1)
				    : $urandom_range(0, KEYS_PER_TRACK - 1);
				l = ($urandom_range(0, 3) == 0) && prefix_written(t, s);
				put_key(t, s, ($urandom_range(0, 1) == 1) ? $urandom() : frame_mirror[t][s],
				        pick_weight(), l);
			end else begin
				t = $urandom_range(0, TRACKS - 1);
				ask_weight(t, (count_mirror[t] != 0) ? pick_query_frame(t) : $urandom());
			end
		end

		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// Any stray result after the last expected one is still caught here.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
design/kwi_pkg.sv
design/kwi_ram.sv
design/kwi_ctrl.sv
design/kwi_datapath.sv
design/keyframe_weight_interpolator_core.sv
design/kwi_checker.sv
bench/weight_checker.sv
bench/keyframe_weight_interpolator_core_tb.sv
